[src/vtcp_pkg.sv]
`default_nettype none
package vtcp_pkg;

   localparam int CLIP_W = 38;
   localparam int PROD_W = 48;
   localparam int SUM_W = 50;
   localparam int FRAC_W = 16;
   localparam int Q_W = 41;
   localparam int REM_W = CLIP_W + FRAC_W;
   localparam int CMP_W = CLIP_W + Q_W + 1;
   localparam int VP_W = 13;
   localparam int CSR_IDX_W = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_ROW0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_ROW1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_ROW2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX_ROW3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VIEWPORT_WIDTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd5;

   localparam int OC_Z_NEAR = 0;
   localparam int OC_Z_FAR = 1;
   localparam int OC_X_LEFT = 2;
   localparam int OC_X_RIGHT = 3;
   localparam int OC_Y_BOTTOM = 4;
   localparam int OC_Y_TOP = 5;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic signed [31:0] vert_w;
   } req_type;

   typedef struct packed {
      logic [5:0] clip_code;
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic signed [31:0] depth;
      logic w_fault;
   } rsp_type;

   typedef struct packed {
      logic [3:0][63:0] matrix;
      logic [VP_W-1:0] vp_width;
      logic [VP_W-1:0] vp_height;
   } cfg_type;

   typedef struct packed {
      logic [3:0][CLIP_W-1:0] clip;
      logic [5:0] code;
      logic w_zero;
   } clip_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

[src/vertex_transform_clip_project_core.sv]
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   req_data (vertex x, y, z, w)
// rsp      out        rsp_valid / rsp_ready   rsp_data (outcode, screen, depth, fault)
// csr      in         csr_valid / csr_ready   csr_index, csr_data
// One vertex per cycle while responses are taken. Front registers products, clip
// values, outcodes; back: 42-step pipelined restoring divider, scale, output.
// Synchronous reset restores the identity matrix and a 640 by 480 viewport.
// A stalled response holds the back pipeline; the front fills the queue,
// then drops req_ready. csr_ready is always high.
`default_nettype none
module vertex_transform_clip_project_core #(
   parameter int QUEUE_DEPTH = vtcp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire vtcp_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output vtcp_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [vtcp_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [63:0] csr_data
);
   import vtcp_pkg::*;

   cfg_type cfg_ff;
   logic push, pop;
   clip_item_type push_data, pop_data;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix[0] <= 64'd4096;
         cfg_ff.matrix[1] <= 64'd4096 << 16;
         cfg_ff.matrix[2] <= 64'd4096 << 32;
         cfg_ff.matrix[3] <= 64'd4096 << 48;
         cfg_ff.vp_width <= VP_W'(640);
         cfg_ff.vp_height <= VP_W'(480);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MATRIX_ROW0: cfg_ff.matrix[0] <= csr_data;
            REG_MATRIX_ROW1: cfg_ff.matrix[1] <= csr_data;
            REG_MATRIX_ROW2: cfg_ff.matrix[2] <= csr_data;
            REG_MATRIX_ROW3: cfg_ff.matrix[3] <= csr_data;
            REG_VIEWPORT_WIDTH: cfg_ff.vp_width <= csr_data[VP_W-1:0];
            REG_VIEWPORT_HEIGHT: cfg_ff.vp_height <= csr_data[VP_W-1:0];
            default: ;
         endcase
      end
   end

   vtcp_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .push_valid(push), .push_data(push_data), .queue_full(q_status.full)
   );

   vtcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .status(q_status)
   );

   vtcp_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .queue_empty(q_status.empty), .pop(pop), .pop_data(pop_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.w_fault |->
         rsp_data.screen_x == 0 && rsp_data.screen_y == 0 && rsp_data.depth == 0)
      else $error("faulted response carries nonzero results");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_status.full)
      else $error("front stalled with room in the queue");
   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      q_status.full && !pop |-> !push)
      else $error("queue written while full");
   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

[src/vtcp_front.sv]
`default_nettype none
module vtcp_front (
   input wire logic clock,
   input wire logic reset,
   input wire vtcp_pkg::cfg_type cfg,
   input wire logic req_valid,
   output logic req_ready,
   input wire vtcp_pkg::req_type req_data,
   output logic push_valid,
   output vtcp_pkg::clip_item_type push_data,
   input wire logic queue_full
);
   import vtcp_pkg::*;

   logic en;
   logic [2:0] valid_ff, valid_in;
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [CLIP_W-1:0] clip_ff [4];
   clip_item_type item_ff, item_in;
   logic signed [31:0] vin [4];
   logic signed [SUM_W-1:0] acc [4];
   logic signed [CLIP_W:0] c0, c1, c2, c3, ncw;

   assign en = !(valid_ff[2] && queue_full);
   assign req_ready = en;
   assign push_valid = valid_ff[2] && !queue_full;
   assign push_data = item_ff;

   assign vin[0] = req_data.vert_x;
   assign vin[1] = req_data.vert_y;
   assign vin[2] = req_data.vert_z;
   assign vin[3] = req_data.vert_w;

   always_comb begin
      valid_in = {valid_ff[1:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               prod_ff[i][j] <= PROD_W'(vin[i] * $signed(cfg.matrix[i][16*j +: 16]));
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         acc[j] = SUM_W'(prod_ff[0][j]) + SUM_W'(prod_ff[1][j])
                + SUM_W'(prod_ff[2][j]) + SUM_W'(prod_ff[3][j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 4; j++) begin
            clip_ff[j] <= CLIP_W'(acc[j] >>> 12);
         end
      end
   end

   always_comb begin
      c0 = (CLIP_W+1)'(clip_ff[0]);
      c1 = (CLIP_W+1)'(clip_ff[1]);
      c2 = (CLIP_W+1)'(clip_ff[2]);
      c3 = (CLIP_W+1)'(clip_ff[3]);
      ncw = -c3;
      item_in.code = '0;
      item_in.code[OC_Z_NEAR] = c2 < 0;
      item_in.code[OC_Z_FAR] = c2 > c3;
      item_in.code[OC_X_LEFT] = c0 < ncw;
      item_in.code[OC_X_RIGHT] = c0 > c3;
      item_in.code[OC_Y_BOTTOM] = c1 < ncw;
      item_in.code[OC_Y_TOP] = c1 > c3;
      item_in.w_zero = clip_ff[3] == '0;
      for (int j = 0; j < 4; j++) begin
         item_in.clip[j] = clip_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

[src/vtcp_queue.sv]
`default_nettype none
module vtcp_queue #(
   parameter int DEPTH = vtcp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire vtcp_pkg::clip_item_type push_data,
   input wire logic pop,
   output vtcp_pkg::clip_item_type pop_data,
   output vtcp_pkg::queue_status_type status
);
   import vtcp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   clip_item_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign status.full = cnt_ff == CNT_W'(DEPTH);
   assign status.empty = cnt_ff == '0;
   assign pop_data = mem[rd_ff];

   always_comb begin
      wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_in;
         if (pop) rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[src/vtcp_back.sv]
`default_nettype none
module vtcp_back (
   input wire logic clock,
   input wire logic reset,
   input wire vtcp_pkg::cfg_type cfg,
   input wire logic queue_empty,
   output logic pop,
   input wire vtcp_pkg::clip_item_type pop_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output vtcp_pkg::rsp_type rsp_data
);
   import vtcp_pkg::*;

   localparam int NDIV = Q_W + 1;
   localparam logic [Q_W-1:0] RLIM = Q_W'(1) << (Q_W - 1);

   typedef struct packed {
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][Q_W-1:0] quo;
      logic [2:0] neg;
      logic [2:0] ovf;
      logic [CLIP_W-1:0] den;
      logic [5:0] code;
      logic w_zero;
   } div_stage_type;

   logic en;
   logic [NDIV-1:0] dv_ff;
   div_stage_type dp_ff [NDIV];
   div_stage_type d0_in;
   div_stage_type dn_in [NDIV];
   logic m_valid_ff, o_valid_ff;
   logic signed [56:0] px_ff, py_ff;
   logic signed [Q_W:0] rz_ff;
   logic [5:0] m_code_ff;
   logic m_zero_ff;
   rsp_type out_ff, out_in;
   logic signed [Q_W:0] r [3];
   logic signed [Q_W+1:0] ax, ay;
   logic signed [56:0] hx, hy;
   logic signed [CLIP_W-1:0] cc;
   logic [CLIP_W-1:0] cabs;

   assign en = !(o_valid_ff && !rsp_ready);
   assign pop = en && !queue_empty;
   assign rsp_valid = o_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      d0_in = '0;
      d0_in.code = pop_data.code;
      d0_in.w_zero = pop_data.w_zero;
      cc = $signed(pop_data.clip[3]);
      d0_in.den = cc[CLIP_W-1] ? CLIP_W'(-cc) : CLIP_W'(cc);
      for (int k = 0; k < 3; k++) begin
         cc = $signed(pop_data.clip[k]);
         cabs = cc[CLIP_W-1] ? CLIP_W'(-cc) : CLIP_W'(cc);
         d0_in.rem[k] = {cabs, {FRAC_W{1'b0}}};
         d0_in.neg[k] = pop_data.clip[k][CLIP_W-1] ^ pop_data.clip[3][CLIP_W-1];
         d0_in.ovf[k] = CMP_W'({cabs, {FRAC_W{1'b0}}})
                      >= (CMP_W'(d0_in.den) << Q_W);
      end
   end

   always_comb begin
      for (int s = 1; s < NDIV; s++) begin
         dn_in[s] = dp_ff[s-1];
         for (int k = 0; k < 3; k++) begin
            if (CMP_W'(dp_ff[s-1].rem[k]) >= (CMP_W'(dp_ff[s-1].den) << (Q_W - s))) begin
               dn_in[s].rem[k] = REM_W'(CMP_W'(dp_ff[s-1].rem[k])
                               - (CMP_W'(dp_ff[s-1].den) << (Q_W - s)));
               dn_in[s].quo[k][Q_W-s] = 1'b1;
            end
         end
      end
      dn_in[0] = d0_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= {dv_ff[NDIV-2:0], !queue_empty};
         m_valid_ff <= dv_ff[NDIV-1];
         o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NDIV; s++) begin
            dp_ff[s] <= dn_in[s];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dp_ff[NDIV-1].ovf[k] || dp_ff[NDIV-1].quo[k] > RLIM) begin
            r[k] = $signed({1'b0, RLIM});
         end else begin
            r[k] = $signed({1'b0, dp_ff[NDIV-1].quo[k]});
         end
         if (dp_ff[NDIV-1].neg[k]) r[k] = -r[k];
      end
      ax = (Q_W+2)'(65536) + (Q_W+2)'(r[0]);
      ay = (Q_W+2)'(65536) - (Q_W+2)'(r[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= 57'(ax * $signed({1'b0, cfg.vp_width}));
         py_ff <= 57'(ay * $signed({1'b0, cfg.vp_height}));
         rz_ff <= r[2];
         m_code_ff <= dp_ff[NDIV-1].code;
         m_zero_ff <= dp_ff[NDIV-1].w_zero;
      end
   end

   function automatic logic signed [31:0] sat32(input logic signed [56:0] v);
      logic signed [31:0] res;
      if (v > 57'sd2147483647) res = 32'h7FFFFFFF;
      else if (v < -57'sd2147483648) res = 32'h80000000;
      else res = v[31:0];
      return res;
   endfunction

   always_comb begin
      hx = (px_ff + $signed({56'd0, px_ff[56]})) >>> 1;
      hy = (py_ff + $signed({56'd0, py_ff[56]})) >>> 1;
      out_in.clip_code = m_code_ff;
      out_in.w_fault = m_zero_ff;
      if (m_zero_ff) begin
         out_in.screen_x = '0;
         out_in.screen_y = '0;
         out_in.depth = '0;
      end else begin
         out_in.screen_x = sat32(hx);
         out_in.screen_y = sat32(hy);
         out_in.depth = sat32(57'(rz_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import vtcp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] mat_row [4];
   logic [12:0] vp_w, vp_h;
   rsp_type vertex_results [$];
   int errors = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit stall_on = 1'b1;
   bit gaps_on = 1'b1;

   vertex_transform_clip_project_core u_top (.*);

   initial forever #4 clock = ~clock;

   function automatic longint ratio_q16(longint c, longint w);
      longint r;
      r = (c * 64'sd65536) / w;
      if (r > (64'sd1 <<< 40)) r = 64'sd1 <<< 40;
      if (r < -(64'sd1 <<< 40)) r = -(64'sd1 <<< 40);
      return r;
   endfunction

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic rsp_type project_vertex(req_type v);
      rsp_type r;
      longint vin [4];
      longint c [4];
      longint acc, rx, ry, rz;
      logic signed [15:0] coef;
      vin[0] = v.vert_x; vin[1] = v.vert_y; vin[2] = v.vert_z; vin[3] = v.vert_w;
      for (int j = 0; j < 4; j++) begin
         acc = 0;
         for (int i = 0; i < 4; i++) begin
            coef = mat_row[i][16*j +: 16];
            acc += vin[i] * longint'(coef);
         end
         c[j] = acc >>> 12;
      end
      r = '0;
      r.clip_code[OC_Z_NEAR] = c[2] < 0;
      r.clip_code[OC_Z_FAR] = c[2] > c[3];
      r.clip_code[OC_X_LEFT] = c[0] < -c[3];
      r.clip_code[OC_X_RIGHT] = c[0] > c[3];
      r.clip_code[OC_Y_BOTTOM] = c[1] < -c[3];
      r.clip_code[OC_Y_TOP] = c[1] > c[3];
      if (c[3] == 0) begin
         r.w_fault = 1'b1;
      end else begin
         rx = ratio_q16(c[0], c[3]);
         ry = ratio_q16(c[1], c[3]);
         rz = ratio_q16(c[2], c[3]);
         r.screen_x = sat32(((64'sd65536 + rx) * longint'({1'b0, vp_w})) / 2);
         r.screen_y = sat32(((64'sd65536 - ry) * longint'({1'b0, vp_h})) / 2);
         r.depth = sat32(rz);
      end
      return r;
   endfunction

   task automatic idle_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic send_vertex(req_type v);
      idle_gap();
      req_valid <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (!req_ready);
      vertex_results.push_back(project_vertex(v));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (vertex_results.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MATRIX_ROW0, REG_MATRIX_ROW1, REG_MATRIX_ROW2, REG_MATRIX_ROW3: mat_row[idx] = val;
         REG_VIEWPORT_WIDTH: vp_w = val[12:0];
         REG_VIEWPORT_HEIGHT: vp_h = val[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         3: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
         4: return $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_vertex();
      req_type v;
      v.vert_x = rand_coord();
      v.vert_y = rand_coord();
      v.vert_z = rand_coord();
      v.vert_w = rand_coord();
      return v;
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h1000;
         3: return 16'h0;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] ext [6] = '{32'h0, 32'h00010000, 32'hffff0000, 32'h7fffffff,
                               32'h80000000, 32'hffffffff};
      send_vertex('{32'h0, 32'h0, 32'h0, 32'h0});
      send_vertex('{32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000});
      send_vertex('{32'h00020000, 32'hfffe0000, 32'hffff0000, 32'h00010000});
      send_vertex('{32'hfffe0000, 32'h00020000, 32'h00020000, 32'h00010000});
      send_vertex('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000001});
      send_vertex('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff});
      send_vertex('{32'h00008000, 32'h00008000, 32'h00008000, 32'hffff0000});
      for (int i = 0; i < 6; i++)
         send_vertex('{ext[i], ext[5-i], ext[(i+2)%6], ext[(i+4)%6]});
      wait_drained();
   endtask

   task automatic test_viewport_extremes();
      write_reg(REG_VIEWPORT_WIDTH, 64'd0);
      write_reg(REG_VIEWPORT_HEIGHT, 64'h1fff);
      for (int i = 0; i < 6; i++) send_vertex(rand_vertex());
      wait_drained();
      write_reg(REG_VIEWPORT_WIDTH, 64'd4096);
      write_reg(REG_VIEWPORT_HEIGHT, 64'd1);
      for (int i = 0; i < 6; i++) send_vertex(rand_vertex());
      wait_drained();
   endtask

   task automatic test_random_matrices();
      logic [63:0] row;
      for (int phase = 0; phase < 10; phase++) begin
         for (int r = 0; r < 4; r++) begin
            row = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
            if (phase == 0) row = '1;
            if (phase == 1) row = '0;
            if (phase == 2) row = {4{16'h8000}};
            if (phase == 3) row = {4{16'h7fff}};
            write_reg(r[CSR_IDX_W-1:0], row);
         end
         write_reg(REG_VIEWPORT_WIDTH, $urandom_range(1, 4096));
         write_reg(REG_VIEWPORT_HEIGHT, $urandom_range(1, 4096));
         if (phase == 9) begin
            gaps_on = 1'b0;
            stall_on = 1'b0;
         end
         for (int i = 0; i < 100; i++) send_vertex(rand_vertex());
         wait_drained();
      end
   endtask

   initial begin
      rsp_ready <= 1'b0;
      vp_w = 13'd640;
      vp_h = 13'd480;
      mat_row[0] = 64'h1000;
      mat_row[1] = 64'h1000 << 16;
      mat_row[2] = 64'h1000 << 32;
      mat_row[3] = 64'h1000 << 48;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_viewport_extremes();
      test_random_matrices();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
         end else if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vertex_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction %h", $time, rsp_data);
         end else begin
            exp_r = vertex_results.pop_front();
            if (rsp_data.clip_code !== exp_r.clip_code) begin
               errors++;
               $display("%0t: clip_code exp %h got %h", $time, exp_r.clip_code,
                        rsp_data.clip_code);
            end
            if (rsp_data.screen_x !== exp_r.screen_x) begin
               errors++;
               $display("%0t: screen_x exp %h got %h", $time, exp_r.screen_x,
                        rsp_data.screen_x);
            end
            if (rsp_data.screen_y !== exp_r.screen_y) begin
               errors++;
               $display("%0t: screen_y exp %h got %h", $time, exp_r.screen_y,
                        rsp_data.screen_y);
            end
            if (rsp_data.depth !== exp_r.depth) begin
               errors++;
               $display("%0t: depth exp %h got %h", $time, exp_r.depth, rsp_data.depth);
            end
            if (rsp_data.w_fault !== exp_r.w_fault) begin
               errors++;
               $display("%0t: w_fault exp %h got %h", $time, exp_r.w_fault,
                        rsp_data.w_fault);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end
endmodule
`default_nettype wire
